### hw/rtl/stochastic_migration_grid_step_macros.svh
// Assertion macros for the migration grid block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef STOCHASTIC_MIGRATION_GRID_STEP_MACROS_SVH
`define STOCHASTIC_MIGRATION_GRID_STEP_MACROS_SVH

// same-cycle implication
`define SMGS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smgs check failed");

// next-cycle implication
`define SMGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smgs check failed");

`endif

### hw/rtl/smgs_pkg.sv
// Types and constants of the migration grid block.
// No dependencies.
package smgs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CELL_CNT_W = 17;
  localparam int DIM_W      = 9;
  localparam int RSIZE_W    = 13;
  localparam int OFF_W      = 24;
  localparam logic [15:0] ANS_MAX = 16'hFFFF;

  localparam logic [2:0] REQ_LOAD_OCC  = 3'd0;
  localparam logic [2:0] REQ_LOAD_SUIT = 3'd1;
  localparam logic [2:0] REQ_LOAD_RAND = 3'd2;
  localparam logic [2:0] REQ_RUN       = 3'd3;
  localparam logic [2:0] REQ_READ      = 3'd4;

  localparam logic [1:0] MODE_FINAL = 2'd0;
  localparam logic [1:0] MODE_FIRST = 2'd1;
  localparam logic [1:0] MODE_LAST  = 2'd2;
  localparam logic [1:0] MODE_COUNT = 2'd3;

  localparam logic [2:0] REG_OUTPUT_MODE = 3'd0;
  localparam logic [2:0] REG_SIGNED_OUT  = 3'd1;
  localparam logic [2:0] REG_EXT_PROB    = 3'd2;
  localparam logic [2:0] REG_CORNER_PROB = 3'd3;
  localparam logic [2:0] REG_RING_SIZE   = 3'd4;
  localparam logic [2:0] REG_GRID_COLS   = 3'd5;
  localparam logic [2:0] REG_GRID_ROWS   = 3'd6;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] cell_index;
    logic [16:0] load_value;
    logic [23:0] ring_offset;
  } request_t;

  typedef struct packed {
    logic signed [16:0] result_value;
    logic               occupied;
    logic               run_done;
  } result_t;

  typedef struct packed {
    logic [1:0]  output_mode;
    logic        signed_output;
    logic [16:0] extinction_prob;
    logic [16:0] corner_prob;
    logic [12:0] ring_size;
    logic [8:0]  grid_cols;
    logic [8:0]  grid_rows;
  } cfg_t;

endpackage

### hw/rtl/smgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/smgs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on smgs_pkg for operand widths.
module smgs_div import smgs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [OFF_W-1:0]   dividend,
  input  logic [RSIZE_W-1:0] divisor,
  output logic               done,
  output logic [OFF_W-1:0]   quot,
  output logic [RSIZE_W-1:0] rem
);
  localparam int CNT_W = $clog2(OFF_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [RSIZE_W-1:0] dsr;
  logic [RSIZE_W:0] shifted;
  logic fits;

  assign shifted = {rem, quot[OFF_W-1]};
  assign fits = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(OFF_W);
        quot <= dividend;
        rem <= '0;
        dsr <= divisor;
      end else if (cnt != '0) begin
        rem <= fits ? RSIZE_W'(shifted - {1'b0, dsr}) : RSIZE_W'(shifted);
        quot <= {quot[OFF_W-2:0], fits};
        cnt <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end
endmodule

### hw/rtl/smgs_cfg.sv
// APB register file of the migration grid block.
// Depends on smgs_pkg for the register struct and indexes.
module smgs_cfg import smgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  logic [2:0] idx;
  assign idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.output_mode <= MODE_FINAL;
      cfg.signed_output <= 1'b0;
      cfg.extinction_prob <= '0;
      cfg.corner_prob <= '0;
      cfg.ring_size <= 13'd4096;
      cfg.grid_cols <= 9'd256;
      cfg.grid_rows <= 9'd256;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_OUTPUT_MODE: cfg.output_mode <= pwdata[1:0];
        REG_SIGNED_OUT:  cfg.signed_output <= pwdata[0];
        REG_EXT_PROB:    cfg.extinction_prob <= pwdata[16:0];
        REG_CORNER_PROB: cfg.corner_prob <= pwdata[16:0];
        REG_RING_SIZE:   cfg.ring_size <= pwdata[12:0];
        REG_GRID_COLS:   cfg.grid_cols <= pwdata[8:0];
        REG_GRID_ROWS:   cfg.grid_rows <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OUTPUT_MODE: prdata = {30'b0, cfg.output_mode};
      REG_SIGNED_OUT:  prdata = {31'b0, cfg.signed_output};
      REG_EXT_PROB:    prdata = {15'b0, cfg.extinction_prob};
      REG_CORNER_PROB: prdata = {15'b0, cfg.corner_prob};
      REG_RING_SIZE:   prdata = {19'b0, cfg.ring_size};
      REG_GRID_COLS:   prdata = {23'b0, cfg.grid_cols};
      REG_GRID_ROWS:   prdata = {23'b0, cfg.grid_rows};
      default:         prdata = '0;
    endcase
  end
endmodule

### hw/rtl/stochastic_migration_grid_step.sv
// Top level and sequencer of the stochastic migration grid engine.
// Depends on smgs_pkg, smgs_ram, smgs_div, smgs_cfg and the assertion macros.
//
// Use: a request is taken when start is high and busy is low. Every request
// gives one result, shown on result for the single cycle in which result_strobe
// is high; the receiver cannot stall it. Registers are to be written over the
// APB port while the block is idle; the block itself does not enforce this.
// Every request first divides GRID_CELLS by the column count on the shared
// divider (24 steps) to find the row limit; loads, reads and unknown requests
// then pass through the decode, fetch and response states before the strobe.
// A run also divides the ring offset and 11 by the ring size, then makes
// three sweeps over the n = rows*cols cells: extinction (a read, then a write
// of each cell), colonization (a read alone for an edge cell, a read and check
// for an interior cell, then a read and evaluation per draw tried unless the
// cell is skipped), and the answer store update (a read, then a write of each
// cell, skipped in final-distribution mode). Each store has one RAM read port.
// After reset the block sweeps occupancy and answer stores to zero, one
// entry a cycle, with busy high; register writes are taken meanwhile.
`include "stochastic_migration_grid_step_macros.svh"

module stochastic_migration_grid_step import smgs_pkg::*; #(
  parameter int GRID_CELLS = 65536,
  parameter int RING_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        result_strobe,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = $clog2(GRID_CELLS);
  localparam int RW = $clog2(RING_DEPTH);
  localparam logic [3:0] K_SELF   = 4'd1;
  localparam logic [3:0] K_LEFT   = 4'd2;
  localparam logic [3:0] K_RIGHT  = 4'd3;
  localparam logic [3:0] K_BELOW  = 4'd4;
  localparam logic [3:0] K_ABOVE  = 4'd5;
  localparam logic [3:0] K_CORNER = 4'd6;
  localparam logic [3:0] K_BL     = 4'd7;
  localparam logic [3:0] K_BR     = 4'd8;
  localparam logic [3:0] K_AL     = 4'd9;
  localparam logic [3:0] K_AR     = 4'd10;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_LIM_GO, ST_LIM_WAIT, ST_ROWS, ST_SIZE, ST_DECODE,
    ST_OFF_GO, ST_OFF_WAIT, ST_R11_GO, ST_R11_WAIT, ST_EXT_RD, ST_EXT_WR,
    ST_COL_RD, ST_COL_CHK, ST_TRY_RD, ST_TRY_EVAL, ST_UPD_RD, ST_UPD_WR,
    ST_FINISH, ST_FETCH, ST_RESP
  } state_t;

  state_t state;
  cfg_t cfg;
  request_t req;
  logic [AW-1:0] clr;
  logic [DIM_W-1:0] rows_eff, row, col;
  logic [CELL_CNT_W-1:0] n, p;
  logic [RSIZE_W-1:0] base, kidx, off_mod, r11;
  logic [3:0] k;
  logic [16:0] suit_s;
  logic [15:0] step_count;
  logic in_grid;

  smgs_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // effective shape and ring size
  logic [DIM_W-1:0] cols_eff, rows_c;
  logic [RSIZE_W-1:0] rs;
  always_comb begin
    cols_eff = cfg.grid_cols < 9'd3 ? 9'd3 : (cfg.grid_cols > 9'd256 ? 9'd256 : cfg.grid_cols);
    rows_c = cfg.grid_rows < 9'd3 ? 9'd3 : (cfg.grid_rows > 9'd256 ? 9'd256 : cfg.grid_rows);
    if (cfg.ring_size == '0) begin
      rs = RSIZE_W'(1);
    end else if (32'(cfg.ring_size) > RING_DEPTH) begin
      rs = RSIZE_W'(RING_DEPTH);
    end else begin
      rs = cfg.ring_size;
    end
  end

  // shared divider
  logic div_start, div_done;
  logic [OFF_W-1:0] div_dvd, div_quot;
  logic [RSIZE_W-1:0] div_dsr, div_rem;
  always_comb begin
    div_start = state == ST_LIM_GO || state == ST_OFF_GO || state == ST_R11_GO;
    div_dvd = OFF_W'(11);
    div_dsr = rs;
    case (state)
      ST_LIM_GO: begin
        div_dvd = OFF_W'(GRID_CELLS);
        div_dsr = RSIZE_W'(cols_eff);
      end
      ST_OFF_GO: div_dvd = req.ring_offset;
      default: ;
    endcase
  end

  smgs_div u_div (
    .clk, .rst, .start(div_start), .dividend(div_dvd), .divisor(div_dsr),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  // stores
  logic now_we, now_wd, now_rd, bef_we, bef_rd, suit_we, ring_we, ans_we;
  logic [AW-1:0] now_wa, now_ra, bef_ra, ans_wa, ans_ra;
  logic [16:0] suit_rd;
  logic [FRAC_BITS-1:0] ring_rd, ring_wd;
  logic [RW-1:0] ring_wa, ring_ra;
  logic [15:0] ans_rd, ans_wd;

  smgs_ram #(.WIDTH(1), .DEPTH(GRID_CELLS)) u_now (
    .clk, .we(now_we), .waddr(now_wa), .wdata(now_wd), .raddr(now_ra), .rdata(now_rd)
  );
  smgs_ram #(.WIDTH(1), .DEPTH(GRID_CELLS)) u_before (
    .clk, .we(bef_we), .waddr(AW'(p)), .wdata(now_rd), .raddr(bef_ra), .rdata(bef_rd)
  );
  smgs_ram #(.WIDTH(17), .DEPTH(GRID_CELLS)) u_suit (
    .clk, .we(suit_we), .waddr(AW'(req.cell_index)), .wdata(req.load_value),
    .raddr(AW'(p)), .rdata(suit_rd)
  );
  smgs_ram #(.WIDTH(FRAC_BITS), .DEPTH(RING_DEPTH)) u_ring (
    .clk, .we(ring_we), .waddr(ring_wa), .wdata(ring_wd), .raddr(ring_ra), .rdata(ring_rd)
  );
  smgs_ram #(.WIDTH(16), .DEPTH(GRID_CELLS)) u_ans (
    .clk, .we(ans_we), .waddr(ans_wa), .wdata(ans_wd), .raddr(ans_ra), .rdata(ans_rd)
  );

  // per-cell stepping
  logic [CELL_CNT_W-1:0] cols17, nb;
  logic [RSIZE_W:0] base_sum;
  logic [RSIZE_W-1:0] base_adv, kidx_inc;
  logic last_cell, interior, ext_hit, try_hit, corner_hit;
  logic [15:0] num;
  logic grid_hit;

  always_comb begin
    cols17 = CELL_CNT_W'(cols_eff);
    base_sum = {1'b0, base} + {1'b0, r11};
    base_adv = base_sum >= {1'b0, rs} ? RSIZE_W'(base_sum - {1'b0, rs}) : RSIZE_W'(base_sum);
    kidx_inc = (kidx + 1'b1 == rs) ? '0 : RSIZE_W'(kidx + 1'b1);
    last_cell = p == n - 1'b1;
    interior = row != '0 && row != rows_eff - 1'b1 && col != '0 && col != cols_eff - 1'b1;
    ext_hit = {1'b0, ring_rd} <= cfg.extinction_prob;
    try_hit = {1'b0, ring_rd} <= suit_s;
    corner_hit = {1'b0, ring_rd} <= cfg.corner_prob;
    num = step_count == ANS_MAX ? ANS_MAX : step_count + 1'b1;
    grid_hit = CELL_CNT_W'(req.cell_index) < n;
    case (k)
      K_LEFT:  nb = p - 1'b1;
      K_RIGHT: nb = p + 1'b1;
      K_BELOW: nb = p + cols17;
      K_ABOVE: nb = p - cols17;
      K_BL:    nb = p + cols17 - 1'b1;
      K_BR:    nb = p + cols17 + 1'b1;
      K_AL:    nb = p - cols17 - 1'b1;
      K_AR:    nb = p - cols17 + 1'b1;
      default: nb = p;
    endcase
  end

  // store port muxes
  always_comb begin
    now_we = 1'b0;
    now_wa = AW'(p);
    now_wd = 1'b0;
    now_ra = AW'(p);
    bef_we = state == ST_EXT_WR;
    bef_ra = AW'(nb);
    suit_we = state == ST_DECODE && req.req_type == REQ_LOAD_SUIT && grid_hit;
    ring_we = state == ST_DECODE && req.req_type == REQ_LOAD_RAND &&
              32'(req.cell_index) < RING_DEPTH;
    ring_wa = RW'(req.cell_index);
    ring_wd = req.load_value[16] ? {FRAC_BITS{1'b1}} : req.load_value[FRAC_BITS-1:0];
    ring_ra = (state == ST_TRY_RD) ? RW'(kidx) : RW'(base);
    ans_we = 1'b0;
    ans_wa = AW'(p);
    ans_ra = AW'(p);
    ans_wd = ans_rd;
    case (state)
      ST_CLEAR: begin
        now_we = 1'b1;
        now_wa = clr;
        ans_we = 1'b1;
        ans_wa = clr;
        ans_wd = '0;
      end
      ST_DECODE: begin
        now_we = req.req_type == REQ_LOAD_OCC && grid_hit;
        now_wa = AW'(req.cell_index);
        now_wd = req.load_value != '0;
      end
      ST_EXT_WR: begin
        now_we = 1'b1;
        now_wd = now_rd && !ext_hit;
      end
      ST_TRY_EVAL: begin
        now_we = k != K_CORNER && bef_rd && try_hit;
        now_wd = 1'b1;
      end
      ST_UPD_WR: begin
        ans_we = now_rd;
        case (cfg.output_mode)
          MODE_FIRST: ans_wd = ans_rd == '0 ? num : ans_rd;
          MODE_LAST:  ans_wd = num;
          MODE_COUNT: ans_wd = ans_rd < ANS_MAX ? ans_rd + 1'b1 : ans_rd;
          default:    ans_wd = ans_rd;
        endcase
      end
      ST_FETCH: begin
        now_ra = AW'(req.cell_index);
        ans_ra = AW'(req.cell_index);
      end
      default: ;
    endcase
  end

  // result of the current request
  result_t result_next;
  always_comb begin
    result_next = '0;
    result_next.run_done = req.req_type == REQ_RUN;
    result_next.occupied = in_grid && now_rd && req.req_type != REQ_LOAD_RAND &&
                           req.req_type <= REQ_READ;
    if (in_grid && req.req_type == REQ_READ) begin
      if (cfg.signed_output && !now_rd) begin
        result_next.result_value = (cfg.output_mode == MODE_FINAL) ?
          17'sd0 : -$signed({1'b0, ans_rd});
      end else begin
        result_next.result_value = (cfg.output_mode == MODE_FINAL) ?
          $signed({16'b0, now_rd}) : $signed({1'b0, ans_rd});
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      step_count <= '0;
      result_strobe <= 1'b0;
      result <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(GRID_CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          result_strobe <= 1'b0;
          result <= '0;
          if (start) begin
            req <= request;
            state <= ST_LIM_GO;
          end
        end
        ST_LIM_GO: state <= ST_LIM_WAIT;
        ST_LIM_WAIT: begin
          if (div_done) begin
            rows_eff <= (div_quot < OFF_W'(rows_c)) ? DIM_W'(div_quot) : rows_c;
            state <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          n <= CELL_CNT_W'(cols_eff * rows_eff);
          state <= ST_SIZE;
        end
        ST_SIZE: state <= ST_DECODE;
        ST_DECODE: begin
          in_grid <= grid_hit;
          p <= '0;
          row <= '0;
          col <= '0;
          if (req.req_type == REQ_RUN) begin
            state <= ST_OFF_GO;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_OFF_GO: state <= ST_OFF_WAIT;
        ST_OFF_WAIT: begin
          if (div_done) begin
            off_mod <= div_rem;
            state <= ST_R11_GO;
          end
        end
        ST_R11_GO: state <= ST_R11_WAIT;
        ST_R11_WAIT: begin
          if (div_done) begin
            r11 <= div_rem;
            base <= off_mod;
            state <= (n == '0) ? ST_FINISH : ST_EXT_RD;
          end
        end
        ST_EXT_RD: state <= ST_EXT_WR;
        ST_EXT_WR: begin
          if (last_cell) begin
            p <= '0;
            base <= off_mod;
            state <= ST_COL_RD;
          end else begin
            p <= p + 1'b1;
            base <= base_adv;
            state <= ST_EXT_RD;
          end
        end
        ST_COL_RD: begin
          if (interior) begin
            state <= ST_COL_CHK;
          end else if (last_cell) begin
            p <= '0;
            state <= (cfg.output_mode == MODE_FINAL) ? ST_FINISH : ST_UPD_RD;
          end else begin
            p <= p + 1'b1;
            base <= base_adv;
            col <= (col == cols_eff - 1'b1) ? '0 : col + 1'b1;
            row <= (col == cols_eff - 1'b1) ? row + 1'b1 : row;
          end
        end
        ST_COL_CHK: begin
          suit_s <= suit_rd;
          k <= K_SELF;
          kidx <= (base + 1'b1 == rs) ? '0 : RSIZE_W'(base + 1'b1);
          if (suit_rd == '0 || now_rd) begin
            if (last_cell) begin
              p <= '0;
              state <= (cfg.output_mode == MODE_FINAL) ? ST_FINISH : ST_UPD_RD;
            end else begin
              p <= p + 1'b1;
              base <= base_adv;
              col <= (col == cols_eff - 1'b1) ? '0 : col + 1'b1;
              row <= (col == cols_eff - 1'b1) ? row + 1'b1 : row;
              state <= ST_COL_RD;
            end
          end else begin
            state <= ST_TRY_RD;
          end
        end
        ST_TRY_RD: state <= ST_TRY_EVAL;
        ST_TRY_EVAL: begin
          if ((k == K_CORNER && !corner_hit) || (k != K_CORNER && bef_rd && try_hit) ||
              k == K_AR) begin
            if (last_cell) begin
              p <= '0;
              state <= (cfg.output_mode == MODE_FINAL) ? ST_FINISH : ST_UPD_RD;
            end else begin
              p <= p + 1'b1;
              base <= base_adv;
              col <= (col == cols_eff - 1'b1) ? '0 : col + 1'b1;
              row <= (col == cols_eff - 1'b1) ? row + 1'b1 : row;
              state <= ST_COL_RD;
            end
          end else begin
            k <= k + 1'b1;
            kidx <= kidx_inc;
            state <= ST_TRY_RD;
          end
        end
        ST_UPD_RD: state <= ST_UPD_WR;
        ST_UPD_WR: begin
          if (last_cell) begin
            state <= ST_FINISH;
          end else begin
            p <= p + 1'b1;
            state <= ST_UPD_RD;
          end
        end
        ST_FINISH: begin
          step_count <= num;
          state <= ST_FETCH;
        end
        ST_FETCH: state <= ST_RESP;
        ST_RESP: begin
          result_strobe <= 1'b1;
          result <= result_next;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = state != ST_IDLE;

  `SMGS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `SMGS_ASSERT_NEXT(a_single_strobe, clk, rst, result_strobe, !result_strobe)
  `SMGS_ASSERT_IMPL(a_done_strobed, clk, rst, result.run_done, result_strobe)
  `SMGS_ASSERT_IMPL(a_idle_after_strobe, clk, rst, result_strobe, !busy)
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for stochastic_migration_grid_step: drives requests and
// APB register writes, predicts every result in a local grid model and compares.
// Depends on smgs_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import smgs_pkg::*;

  localparam logic [2:0] REQ_UNKNOWN_LO = REQ_READ + 3'd1;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'h7;
  localparam int unsigned RUN_CELLS_MAX = 25;
  localparam int unsigned RING_FILL = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  request_t    request = '0;
  logic        result_strobe;
  result_t     result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  stochastic_migration_grid_step dut (
    .clk, .rst, .start, .busy, .request, .result_strobe, .result,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #1 clk = ~clk;

  // grid model
  bit          occ_now [65536];
  bit          occ_prev [65536];
  logic [16:0] suit [65536];
  logic [15:0] ring [4096];
  logic [15:0] answers [65536];
  int unsigned run_count = 0;

  logic [1:0]  mode = MODE_FINAL;
  bit          signed_out = 1'b0;
  logic [16:0] ext_thr = '0;
  logic [16:0] corner_thr = '0;
  logic [12:0] ring_len = 13'd4096;
  logic [8:0]  cols_reg = 9'd256;
  logic [8:0]  rows_reg = 9'd256;

  result_t     pending [$];
  result_t     want;
  int          mismatches = 0;
  bit          no_idle = 1'b0;

  function automatic int unsigned clampv(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned cols_eff();
    return clampv(32'(cols_reg), 3, 256);
  endfunction

  function automatic int unsigned rows_eff();
    int unsigned r;
    int unsigned lim;
    r = clampv(32'(rows_reg), 3, 256);
    lim = 65536 / cols_eff();
    return r > lim ? lim : r;
  endfunction

  function automatic int unsigned ring_draw(longint unsigned base, int k, int unsigned rs);
    return ring[(base + k) % rs];
  endfunction

  function automatic void run_generation(longint unsigned off);
    int unsigned cols, rows, rs, n, p, s, num;
    longint unsigned base;
    bit hit;
    cols = cols_eff();
    rows = rows_eff();
    rs = clampv(32'(ring_len), 1, 4096);
    n = cols * rows;
    for (int i = 0; i < n; i++) occ_prev[i] = occ_now[i];
    for (int i = 0; i < n; i++) begin
      base = (off + longint'(i) * 11) % rs;
      if (occ_prev[i] && ring_draw(base, 0, rs) <= ext_thr) occ_now[i] = 1'b0;
    end
    for (int r = 1; r + 1 < rows; r++) begin
      for (int c = 1; c + 1 < cols; c++) begin
        p = r * cols + c;
        s = 32'(suit[p]);
        if (s == 0 || occ_now[p]) continue;
        base = (off + longint'(p) * 11) % rs;
        hit = 1'b0;
        if (occ_prev[p]) hit = ring_draw(base, 1, rs) <= s;
        if (!hit && occ_prev[p - 1]) hit = ring_draw(base, 2, rs) <= s;
        if (!hit && occ_prev[p + 1]) hit = ring_draw(base, 3, rs) <= s;
        if (!hit && occ_prev[p + cols]) hit = ring_draw(base, 4, rs) <= s;
        if (!hit && occ_prev[p - cols]) hit = ring_draw(base, 5, rs) <= s;
        if (!hit && ring_draw(base, 6, rs) <= corner_thr) begin
          if (occ_prev[p + cols - 1]) hit = ring_draw(base, 7, rs) <= s;
          if (!hit && occ_prev[p + cols + 1]) hit = ring_draw(base, 8, rs) <= s;
          if (!hit && occ_prev[p - cols - 1]) hit = ring_draw(base, 9, rs) <= s;
          if (!hit && occ_prev[p - cols + 1]) hit = ring_draw(base, 10, rs) <= s;
        end
        if (hit) occ_now[p] = 1'b1;
      end
    end
    num = run_count + 1;
    if (num > ANS_MAX) num = ANS_MAX;
    for (int i = 0; i < n; i++) begin
      if (!occ_now[i]) continue;
      if (mode == MODE_FIRST) begin
        if (answers[i] == 0) answers[i] = num[15:0];
      end else if (mode == MODE_LAST) begin
        answers[i] = num[15:0];
      end else if (mode == MODE_COUNT) begin
        if (answers[i] < ANS_MAX) answers[i] = answers[i] + 16'd1;
      end
    end
    if (run_count < ANS_MAX) run_count++;
  endfunction

  function automatic result_t predict_result(request_t rq);
    int unsigned n, idx, v;
    bit in_grid;
    result_t r;
    r = '0;
    n = cols_eff() * rows_eff();
    idx = 32'(rq.cell_index);
    in_grid = idx < n;
    case (rq.req_type)
      REQ_LOAD_OCC: if (in_grid) occ_now[idx] = rq.load_value != 0;
      REQ_LOAD_SUIT: if (in_grid) suit[idx] = rq.load_value;
      REQ_LOAD_RAND: begin
        if (idx < 4096) ring[idx] = rq.load_value > 65535 ? 16'hFFFF : rq.load_value[15:0];
      end
      REQ_RUN: begin
        run_generation(64'(rq.ring_offset));
        r.run_done = 1'b1;
      end
      REQ_READ: begin
        if (in_grid) begin
          v = mode == MODE_FINAL ? 32'(occ_now[idx]) : 32'(answers[idx]);
          if (signed_out && !occ_now[idx]) v = 0 - v;
          r.result_value = v[16:0];
        end
      end
      default: ;
    endcase
    if (rq.req_type <= REQ_READ && rq.req_type != REQ_LOAD_RAND && in_grid)
      r.occupied = occ_now[idx];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", result);
      end else begin
        want = pending.pop_front();
        if (result.result_value !== want.result_value || result.occupied !== want.occupied ||
            result.run_done !== want.run_done) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, result);
        end
      end
    end
  end

  task automatic send(request_t rq);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    pending.push_back(predict_result(rq));
  endtask

  task automatic send_fields(logic [2:0] kind, logic [15:0] idx, logic [16:0] value,
                             logic [23:0] off);
    request_t rq;
    rq.req_type = kind;
    rq.cell_index = idx;
    rq.load_value = value;
    rq.ring_offset = off;
    send(rq);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_OUTPUT_MODE: mode = value[1:0];
      REG_SIGNED_OUT:  signed_out = value[0];
      REG_EXT_PROB:    ext_thr = value[16:0];
      REG_CORNER_PROB: corner_thr = value[16:0];
      REG_RING_SIZE:   ring_len = value[12:0];
      REG_GRID_COLS:   cols_reg = value[8:0];
      REG_GRID_ROWS:   rows_reg = value[8:0];
      default: ;
    endcase
  endtask

  // Runs use at most RING_FILL ring entries and grids of at most 5 by 5 cells.
  task automatic test_fill_stores();
    logic [16:0] value;
    for (int i = 0; i < RING_FILL; i++) begin
      value = 17'($urandom_range(0, 65536));
      if (i == 0) value = '0;
      if (i == 1) value = 17'd65535;
      if (i == 2) value = 17'h10000;
      send_fields(REQ_LOAD_RAND, i[15:0], value, 24'($urandom));
    end
    for (int i = 0; i < RUN_CELLS_MAX; i++) begin
      value = $urandom_range(0, 4) == 0 ? 17'd0 : 17'($urandom_range(1, 65536));
      if (i == 3) value = 17'h10000;
      send_fields(REQ_LOAD_SUIT, i[15:0], value, 24'($urandom));
    end
    settle();
  endtask

  task automatic test_directed();
    reg_write(REG_GRID_COLS, 32'd0);
    reg_write(REG_GRID_ROWS, 32'd2);
    reg_write(REG_RING_SIZE, 32'(RING_FILL));
    send_fields(REQ_LOAD_OCC, 16'd4, 17'h10000, 24'd0);
    send_fields(REQ_LOAD_OCC, 16'd1, 17'd1, 24'd0);
    send_fields(REQ_LOAD_OCC, 16'hFFFF, 17'd1, 24'd0);
    send_fields(REQ_LOAD_SUIT, 16'hFFFF, 17'd5, 24'd0);
    send_fields(REQ_LOAD_RAND, 16'hFFFF, 17'd7, 24'd0);
    for (logic [3:0] k = REQ_UNKNOWN_LO; k <= REQ_UNKNOWN_HI; k++)
      send_fields(k[2:0], 16'd4, 17'h1FFFF, 24'hFFFFFF);
    send_fields(REQ_RUN, 16'd4, 17'd0, 24'hFFFFFF);
    send_fields(REQ_READ, 16'd4, 17'd0, 24'd0);
    send_fields(REQ_READ, 16'd1, 17'd0, 24'd0);
    send_fields(REQ_READ, 16'hFFFF, 17'd0, 24'd0);
    settle();
    reg_write(REG_OUTPUT_MODE, 32'(MODE_FIRST));
    reg_write(REG_SIGNED_OUT, 32'd1);
    send_fields(REQ_RUN, 16'd1, 17'd0, 24'd0);
    send_fields(REQ_READ, 16'd4, 17'd0, 24'd0);
    send_fields(REQ_READ, 16'd0, 17'd0, 24'd0);
    send_fields(REQ_READ, 16'd8, 17'd0, 24'd0);
    settle();
  endtask

  // Loads and reads only: a run on the full grid would take far too long.
  task automatic test_full_grid();
    reg_write(REG_GRID_COLS, 32'd511);
    reg_write(REG_GRID_ROWS, 32'd511);
    send_fields(REQ_LOAD_OCC, 16'hFFFF, 17'd1, 24'd0);
    send_fields(REQ_READ, 16'hFFFF, 17'd0, 24'd0);
    send_fields(REQ_LOAD_OCC, 16'd40000, 17'd0, 24'd0);
    send_fields(REQ_READ, 16'd40000, 17'd0, 24'd0);
    send_fields(REQ_READ, 16'd4, 17'd0, 24'd0);
    settle();
  endtask

  function automatic request_t gen_request(int unsigned n);
    request_t rq;
    int unsigned pick;
    rq.ring_offset = 24'($urandom);
    rq.load_value = 17'($urandom);
    rq.cell_index = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, n - 1));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      rq.req_type = REQ_LOAD_OCC;
      if ($urandom_range(0, 1)) rq.load_value = 17'($urandom_range(0, 1));
    end else if (pick < 38) begin
      rq.req_type = REQ_LOAD_SUIT;
    end else if (pick < 46) begin
      rq.req_type = REQ_LOAD_RAND;
      if ($urandom_range(0, 3) != 0) rq.cell_index = 16'($urandom_range(0, 4095));
    end else if (pick < 60) begin
      rq.req_type = REQ_RUN;
    end else if (pick < 95) begin
      rq.req_type = REQ_READ;
    end else begin
      rq.req_type = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
    end
    return rq;
  endfunction

  task automatic test_random_phases();
    int unsigned n;
    logic [31:0] cols_w, rows_w, ring_w, ext_w, corner_w;
    for (int p = 0; p < 8; p++) begin
      cols_w = $urandom_range(3, 5);
      rows_w = $urandom_range(3, 5);
      if (p == 2) begin cols_w = 0; rows_w = 1; end
      if (p == 5) begin cols_w = 5; rows_w = 3; end
      ring_w = p == 0 ? 1 : (p == 1 ? 0 : (p == 3 ? RING_FILL : $urandom_range(1, RING_FILL)));
      ext_w = p == 1 ? 65536 : (p == 4 ? 0 : $urandom_range(0, 20000));
      corner_w = p == 3 ? 65536 : (p == 6 ? 0 : $urandom_range(0, 65536));
      reg_write(REG_OUTPUT_MODE, p % 4);
      reg_write(REG_SIGNED_OUT, (p >> 1) & 1);
      reg_write(REG_EXT_PROB, ext_w);
      reg_write(REG_CORNER_PROB, corner_w);
      reg_write(REG_RING_SIZE, ring_w);
      reg_write(REG_GRID_COLS, cols_w);
      reg_write(REG_GRID_ROWS, rows_w);
      n = cols_eff() * rows_eff();
      no_idle = p == 7;
      for (int k = 0; k < 6; k++) send(gen_request(n));
      settle();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_fill_stores();
    test_directed();
    test_full_grid();
    test_random_phases();
    settle();
    if (mismatches == 0 && pending.size() == 0) begin
      $display("stochastic_migration_grid_step regression: pass");
    end else begin
      $display("stochastic_migration_grid_step regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("stochastic_migration_grid_step regression: fail");
    $finish;
  end

endmodule

### stochastic_migration_grid_step.f
+incdir+hw/rtl
hw/rtl/smgs_pkg.sv
hw/rtl/smgs_ram.sv
hw/rtl/smgs_div.sv
hw/rtl/smgs_cfg.sv
hw/rtl/stochastic_migration_grid_step.sv
tb/sv/testbench.sv
